/* rtl/bis_pkg.sv */
// bis_pkg: shared types and constants for the bilinear image scaler
// depends on nothing
package bis_pkg;

  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_NUM     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_DEN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_MODE    = 3'd4;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EMIT = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SIZE,
    ST_DIV,
    ST_ADDR,
    ST_RD,
    ST_WAIT,
    ST_MUL1,
    ST_MUL2,
    ST_SUM,
    ST_OUT
  } bis_state_t;

endpackage

/* rtl/bilinear_image_scaler_unit.sv */
// Bilinear image scaler: a frame store memory with a sequencer that fetches
// four neighbors and blends them. Depends on bis_pkg.
//
// Usage:
//  - cfg_* writes one register (0 width, 1 height, 2 numerator,
//    3 denominator, 4 color mode); write only while the block is idle.
//  - in_* carries one transaction: tuser = command (0 load, 1 emit),
//    tdata = {blue, green, red}. A load writes the next source pixel in
//    raster order and yields no result.
//  - an emit yields one out_* transaction with the next output pixel in
//    raster order; out_tlast marks the last pixel of the frame.
//  - a load is written as it is taken; loads follow back to back when idle.
//  - an emit raises out_tvalid after a shared serial divider finds both
//    output sizes (13 quotient bits each) and both steps (8+FRAC_BITS bits
//    each), one bit a cycle with a handover step after each division,
//    then after four reads of the single-port frame memory, one per cycle,
//    then the blend in two registered stages.
//  - the result waits in an output register; the next item is accepted
//    while it waits, but a following emit stalls until it is taken.
//  - reset (rst_n low, synchronous) clears counters, positions, the output
//    valid and the configuration registers to their defaults; the frame
//    store is undefined until loaded and needs no clearing pass.
module bilinear_image_scaler_unit
  import bis_pkg::*;
#(
  parameter int unsigned FRAC_BITS         = 16,
  parameter int unsigned MAX_SOURCE_PIXELS = 16384,
  parameter int unsigned MAX_OUTPUT_SIZE   = 2048
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [23:0]          in_tdata,   // red, green, blue from bit 0
  input  logic                 in_tuser,   // command
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [23:0]          out_tdata,  // red, green, blue from bit 0
  output logic                 out_tlast   // frame_last
);

  localparam int unsigned AW  = $clog2(MAX_SOURCE_PIXELS);
  localparam int unsigned OSW = $clog2(MAX_OUTPUT_SIZE + 1);
  localparam int unsigned NW  = 8 + FRAC_BITS;
  localparam int unsigned DCW = $clog2(NW + 1);
  localparam logic [OSW-1:0] OMAX = OSW'(MAX_OUTPUT_SIZE);
  localparam logic [15:0] LIM_MAX =
    (MAX_SOURCE_PIXELS > 16384) ? 16'd16384 : 16'(MAX_SOURCE_PIXELS);
  localparam logic [FRAC_BITS-1:0] FMASK = '1;

  // configuration registers
  logic [7:0] src_w_r, src_h_r;
  logic [4:0] num_r, den_r;
  logic       mode_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= 8'd128;
      src_h_r <= 8'd128;
      num_r   <= 5'd1;
      den_r   <= 5'd1;
      mode_r  <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SOURCE_WIDTH:  src_w_r <= cfg_data;
        REG_SOURCE_HEIGHT: src_h_r <= cfg_data;
        REG_SCALE_NUM:     num_r   <= cfg_data[4:0];
        REG_SCALE_DEN:     den_r   <= cfg_data[4:0];
        REG_COLOR_MODE:    mode_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [7:0] w, h;
  logic [4:0] den1;
  assign w    = (src_w_r == 8'd0) ? 8'd1 : src_w_r;
  assign h    = (src_h_r == 8'd0) ? 8'd1 : src_h_r;
  assign den1 = (den_r == 5'd0) ? 5'd1 : den_r;

  // frame store
  logic [23:0] mem [MAX_SOURCE_PIXELS];
  logic        mem_we;
  logic [AW-1:0] mem_addr;
  logic [23:0] mem_wdata, mem_rdata_r;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    mem_rdata_r <= mem[mem_addr];
  end

  // sequencer state
  bis_state_t state_r, state_nxt;
  logic [AW:0]      load_addr_r;
  logic [10:0]      col_r, row_r;
  logic [31:0]      xpos_r, ypos_r;
  logic [OSW-1:0]   ow_r, oh_r;
  logic [NW-1:0]    rem_r, quo_r, qx_r;
  logic [DCW-1:0]   dcnt_r;
  logic [1:0]       dph_r;
  logic [1:0]       rcnt_r;
  logic [AW-1:0]    a_r [4];
  logic [23:0]      p_r [4];
  logic [FRAC_BITS-1:0] dx_r, dy_r, dxy_r;
  logic signed [9:0]    t1_r [3], t2_r [3];
  logic signed [10:0]   top_r, bot_r;
  logic signed [9:0]    base_r [3];
  logic [23:0]      res_r;
  logic             last_r, ovalid_r;

  // output size limits for one axis
  function automatic logic [OSW-1:0] osat(input logic [12:0] q);
    begin
      if (q == 13'd0) osat = OSW'(1);
      else if (q > 13'(MAX_OUTPUT_SIZE)) osat = OMAX;
      else osat = OSW'(q);
    end
  endfunction

  // floored product of a signed value and a fraction
  function automatic logic signed [11:0] fm(input logic signed [11:0] a,
                                            input logic [FRAC_BITS-1:0] f);
    logic signed [FRAC_BITS+13:0] p;
    begin
      p  = a * $signed({1'b0, f});
      fm = 12'(p >>> FRAC_BITS);
    end
  endfunction

  function automatic logic [7:0] clip(input logic signed [11:0] v);
    begin
      if (v < 0) clip = 8'd0;
      else if (v > 12'sd255) clip = 8'd255;
      else clip = v[7:0];
    end
  endfunction

  function automatic logic signed [11:0] ch(input logic [23:0] p, input int c);
    begin
      ch = $signed({4'd0, p[8*c +: 8]});
    end
  endfunction

  // scaled sizes before the denominator division
  logic [12:0] prod_w, prod_h;
  assign prod_w = w * num_r;
  assign prod_h = h * num_r;

  // shared restoring divider: sizes by the denominator, then (size << F) / out_size
  logic [NW:0] trial;
  logic [OSW-1:0] dvs;
  logic [DCW-1:0] dend;
  always_comb begin
    unique case (dph_r)
      2'd2:    dvs = ow_r;
      2'd3:    dvs = oh_r;
      default: dvs = OSW'(den1);
    endcase
  end
  assign dend  = dph_r[1] ? DCW'(NW) : DCW'(13);
  assign trial = {rem_r, quo_r[NW-1]} - {{(NW+1-OSW){1'b0}}, dvs};

  // product of the two fractions
  logic [2*FRAC_BITS-1:0] dxy_full;
  assign dxy_full = dx_r * dy_r;

  // neighbor coordinates
  logic [15:0] x0i, y0i, x1i, y1i;
  logic [7:0]  x0, x1, y0, y1;
  assign x0i = xpos_r[31:FRAC_BITS] > 16'hffff ? 16'hffff : 16'(xpos_r >> FRAC_BITS);
  assign y0i = ypos_r[31:FRAC_BITS] > 16'hffff ? 16'hffff : 16'(ypos_r >> FRAC_BITS);
  assign x1i = x0i + 16'd1;
  assign y1i = y0i + 16'd1;
  assign x0 = (x0i >= {8'd0, w} || (xpos_r >> FRAC_BITS) > 32'hffff) ? w - 8'd1 : x0i[7:0];
  assign x1 = (x1i >= {8'd0, w} || x1i == 16'd0 || (xpos_r >> FRAC_BITS) >= 32'hffff)
              ? w - 8'd1 : x1i[7:0];
  assign y0 = (y0i >= {8'd0, h} || (ypos_r >> FRAC_BITS) > 32'hffff) ? h - 8'd1 : y0i[7:0];
  assign y1 = (y1i >= {8'd0, h} || y1i == 16'd0 || (ypos_r >> FRAC_BITS) >= 32'hffff)
              ? h - 8'd1 : y1i[7:0];

  function automatic logic [AW-1:0] adr(input logic [7:0] x, input logic [7:0] y,
                                        input logic [7:0] ww);
    logic [15:0] s;
    begin
      s   = y * ww + {8'd0, x};
      adr = AW'(s);
    end
  endfunction

  logic [15:0] limit;
  logic [15:0] wh;
  assign wh    = w * h;
  assign limit = (wh > LIM_MAX) ? LIM_MAX : wh;

  logic take_in, take_out;
  assign take_in  = in_tvalid && in_tready;
  assign take_out = out_tvalid && out_tready;
  assign in_tready = (state_r == ST_IDLE) &&
                     (in_tuser == CMD_LOAD || !ovalid_r || out_tready);
  assign out_tvalid = ovalid_r;
  assign out_tdata  = res_r;
  assign out_tlast  = last_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (take_in && in_tuser == CMD_EMIT) state_nxt = ST_SIZE;
      ST_SIZE: state_nxt = ST_DIV;
      ST_DIV:  if (dcnt_r == dend && dph_r == 2'd3) state_nxt = ST_ADDR;
      ST_ADDR: state_nxt = ST_RD;
      ST_RD:   if (rcnt_r == 2'd3) state_nxt = ST_WAIT;
      ST_WAIT: state_nxt = ST_MUL1;
      ST_MUL1: state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_OUT;
      ST_OUT:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // memory port control
  logic [AW-1:0] la;
  assign la = (32'(load_addr_r) >= 32'(limit)) ? '0 : load_addr_r[AW-1:0];
  always_comb begin
    mem_we    = take_in && in_tuser == CMD_LOAD;
    mem_wdata = in_tdata;
    mem_addr  = mem_we ? la : a_r[rcnt_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // datapath and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_addr_r <= '0;
      col_r <= '0;
      row_r <= '0;
      xpos_r <= '0;
      ypos_r <= '0;
      ovalid_r <= 1'b0;
    end else begin
      if (take_out) ovalid_r <= 1'b0;
      if (mem_we) begin
        load_addr_r <= (32'(la) + 32'd1 >= 32'(limit)) ? '0
                       : (AW+1)'(la) + (AW+1)'(1);
      end
      unique case (state_r)
        ST_SIZE: begin
          rem_r  <= '0;
          quo_r  <= {prod_w, {(NW-13){1'b0}}};
          dcnt_r <= '0;
          dph_r  <= 2'd0;
        end
        ST_DIV: begin
          if (dcnt_r == dend) begin
            rem_r  <= '0;
            dcnt_r <= '0;
            dph_r  <= dph_r + 2'd1;
            unique case (dph_r)
              2'd0: begin
                ow_r  <= osat(quo_r[12:0]);
                quo_r <= {prod_h, {(NW-13){1'b0}}};
              end
              2'd1: begin
                oh_r  <= osat(quo_r[12:0]);
                quo_r <= NW'({w, {FRAC_BITS{1'b0}}});
              end
              2'd2: begin
                qx_r  <= quo_r;
                quo_r <= NW'({h, {FRAC_BITS{1'b0}}});
              end
              default: ;  // y step stays in quo_r
            endcase
          end else begin
            dcnt_r <= dcnt_r + 1'b1;
            if (!trial[NW]) begin
              rem_r <= trial[NW-1:0];
              quo_r <= {quo_r[NW-2:0], 1'b1};
            end else begin
              rem_r <= {rem_r[NW-2:0], quo_r[NW-1]};
              quo_r <= {quo_r[NW-2:0], 1'b0};
            end
          end
        end
        ST_ADDR: begin
          a_r[0] <= adr(x0, y0, w);
          a_r[1] <= adr(x1, y0, w);
          a_r[2] <= adr(x0, y1, w);
          a_r[3] <= adr(x1, y1, w);
          dx_r   <= xpos_r[FRAC_BITS-1:0] & FMASK;
          dy_r   <= ypos_r[FRAC_BITS-1:0] & FMASK;
          rcnt_r <= 2'd0;
        end
        ST_RD: begin
          rcnt_r <= rcnt_r + 2'd1;
          if (rcnt_r != 2'd0) p_r[rcnt_r - 2'd1] <= mem_rdata_r;
        end
        ST_WAIT: begin
          p_r[3] <= mem_rdata_r;
          dxy_r  <= dxy_full[2*FRAC_BITS-1:FRAC_BITS];
        end
        ST_MUL1: begin
          for (int c = 0; c < 3; c++) begin
            base_r[c] <= 10'(ch(p_r[0], c));
            t1_r[c]   <= 10'(fm(ch(p_r[1], c) - ch(p_r[0], c), dx_r));
            t2_r[c]   <= 10'(fm(ch(p_r[2], c) - ch(p_r[0], c), dy_r)
                           + fm(ch(p_r[0], c) - ch(p_r[1], c) - ch(p_r[2], c)
                                + ch(p_r[3], c), dxy_r));
          end
          top_r <= 11'(ch(p_r[0], 0) + fm(ch(p_r[1], 0) - ch(p_r[0], 0), dx_r));
          bot_r <= 11'(ch(p_r[2], 0) + fm(ch(p_r[3], 0) - ch(p_r[2], 0), dx_r));
        end
        ST_MUL2: begin
          if (!mode_r) begin
            res_r <= {16'd0, clip(12'(top_r) + fm(12'(bot_r) - 12'(top_r), dy_r))};
          end else begin
            for (int c = 0; c < 3; c++)
              res_r[8*c +: 8] <= clip(12'(base_r[c]) + 12'(t1_r[c]) + 12'(t2_r[c]));
          end
        end
        ST_SUM: begin
          last_r <= 1'b0;
          if ({5'd0, col_r} + 16'd1 >= 16'(ow_r)) begin
            col_r  <= '0;
            xpos_r <= '0;
            if ({5'd0, row_r} + 16'd1 >= 16'(oh_r)) begin
              row_r  <= '0;
              ypos_r <= '0;
              last_r <= 1'b1;
            end else begin
              row_r  <= row_r + 11'd1;
              ypos_r <= ypos_r + 32'(quo_r);
            end
          end else begin
            col_r  <= col_r + 11'd1;
            xpos_r <= xpos_r + 32'(qx_r);
          end
        end
        ST_OUT: ovalid_r <= 1'b1;
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  // emit result must not overwrite a waiting one
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT) |-> (!ovalid_r || out_tready))
    else $error("result overrun");
  // load address stays inside the store
  a_load_range: assert property (@(posedge clk) disable iff (!rst_n)
    load_addr_r <= (AW+1)'(MAX_SOURCE_PIXELS))
    else $error("load address out of range");
  // no input taken while an emit is in flight
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_tready)
    else $error("input accepted while busy");
  // output sizes stay in range
  a_osize: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ADDR) |-> (ow_r >= 1 && ow_r <= OMAX && oh_r >= 1 && oh_r <= OMAX))
    else $error("output size out of range");
`endif

endmodule

/* dv/tb.sv */
// tb: self-checking testbench for bilinear_image_scaler_unit
// depends on bis_pkg and the scaler rtl; a directed table, then random frames in three flow modes
module tb;
  import bis_pkg::*;

  localparam int FRAC = 16;
  localparam int STORE_DEPTH = 16384;
  localparam int OUT_MAX = 2048;
  localparam int STALL_LIMIT = 5000;

  typedef enum bit [1:0] {ROW_CFG, ROW_PIX} row_kind_t;

  typedef struct {
    row_kind_t        kind;
    logic [2:0]       idx;
    logic [23:0]      data;
    logic             cmd;
    bit               typed;
    logic [23:0]      want_px;
    bit               want_last;
  } row_t;

  typedef struct {
    logic [23:0] px;
    bit          last;
  } pixel_result_t;

  logic clk, rst_n;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0] cfg_data;
  logic in_tvalid, in_tready;
  logic [23:0] in_tdata;   // red, green, blue from bit 0
  logic in_tuser;          // command
  logic out_tvalid, out_tready;
  logic [23:0] out_tdata;  // red, green, blue from bit 0
  logic out_tlast;         // frame_last

  // typed expectation traveling alongside the driven item
  bit          item_typed;
  logic [23:0] item_px;
  bit          item_last;

  bilinear_image_scaler_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  // scaler mirror state
  logic [23:0] pixel_store [STORE_DEPTH];
  int unsigned load_ptr, col_cnt, row_cnt;
  bit [31:0] src_x, src_y;
  int unsigned reg_w, reg_h, reg_num, reg_den;
  bit reg_rgb;

  pixel_result_t pending_px[$];
  int errors;
  int idle_cycles;
  int snd_idle, rcv_idle;
  int hold_off;
  int sent;
  row_t rows[$];

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned nz(int unsigned v);
    return v == 0 ? 1 : v;
  endfunction

  function automatic int unsigned scaled_size(int unsigned s);
    int unsigned n;
    n = s * reg_num / nz(reg_den);
    if (n < 1) n = 1;
    if (n > OUT_MAX) n = OUT_MAX;
    return n;
  endfunction

  function automatic longint fm(longint a, longint b);
    return (a * b) >>> FRAC;
  endfunction

  function automatic logic [7:0] clip8(longint v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  function automatic int unsigned load_limit();
    int unsigned l;
    l = nz(reg_w) * nz(reg_h);
    return l > STORE_DEPTH ? STORE_DEPTH : l;
  endfunction

  // store one source pixel at the load pointer
  function automatic void mirror_load(logic [23:0] px);
    int unsigned lim;
    lim = load_limit();
    if (load_ptr >= lim) load_ptr = 0;
    pixel_store[load_ptr] = px;
    load_ptr++;
    if (load_ptr >= lim) load_ptr = 0;
  endfunction

  // compute the next output pixel and advance the raster counters
  function automatic pixel_result_t mirror_emit();
    pixel_result_t r;
    int unsigned w, h, ow, oh, x0, x1, y0, y1;
    bit [31:0] xs, ys;
    longint dx, dy, dxy, a, b, c, d, top, bot;
    logic [23:0] p [4];
    w = nz(reg_w);
    h = nz(reg_h);
    ow = scaled_size(w);
    oh = scaled_size(h);
    xs = (w << FRAC) / ow;
    ys = (h << FRAC) / oh;
    x0 = src_x >> FRAC;
    y0 = src_y >> FRAC;
    dx = src_x[FRAC-1:0];
    dy = src_y[FRAC-1:0];
    x1 = x0 + 1;
    y1 = y0 + 1;
    if (x0 >= w) x0 = w - 1;
    if (x1 >= w) x1 = w - 1;
    if (y0 >= h) y0 = h - 1;
    if (y1 >= h) y1 = h - 1;
    p[0] = pixel_store[(y0 * w + x0) % STORE_DEPTH];
    p[1] = pixel_store[(y0 * w + x1) % STORE_DEPTH];
    p[2] = pixel_store[(y1 * w + x0) % STORE_DEPTH];
    p[3] = pixel_store[(y1 * w + x1) % STORE_DEPTH];
    r.px = '0;
    if (!reg_rgb) begin
      a = p[0][7:0]; b = p[1][7:0]; c = p[2][7:0]; d = p[3][7:0];
      top = a + fm(b - a, dx);
      bot = c + fm(d - c, dx);
      r.px[7:0] = clip8(top + fm(bot - top, dy));
    end else begin
      dxy = fm(dx, dy);
      for (int ch = 0; ch < 3; ch++) begin
        a = p[0][8*ch +: 8]; b = p[1][8*ch +: 8];
        c = p[2][8*ch +: 8]; d = p[3][8*ch +: 8];
        r.px[8*ch +: 8] = clip8(a + fm(b - a, dx) + fm(c - a, dy) + fm(a - b - c + d, dxy));
      end
    end
    r.last = 0;
    col_cnt++;
    src_x += xs;
    if (col_cnt >= ow) begin
      col_cnt = 0;
      src_x = 0;
      row_cnt++;
      src_y += ys;
      if (row_cnt >= oh) begin
        row_cnt = 0;
        src_y = 0;
        r.last = 1;
      end
    end
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // watch all three channels: mirror updates, output checks, stall watchdog
  always @(posedge clk) begin
    pixel_result_t e, pr;
    bit act;
    if (rst_n) begin
      act = 0;
      if (cfg_valid && cfg_ready) begin
        act = 1;
        case (cfg_index)
          REG_SOURCE_WIDTH:  reg_w = cfg_data;
          REG_SOURCE_HEIGHT: reg_h = cfg_data;
          REG_SCALE_NUM:     reg_num = cfg_data[4:0];
          REG_SCALE_DEN:     reg_den = cfg_data[4:0];
          REG_COLOR_MODE:    reg_rgb = cfg_data[0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        act = 1;
        if (in_tuser == CMD_LOAD) begin
          mirror_load(in_tdata);
        end else begin
          pr = mirror_emit();
          if (item_typed) begin
            pr.px = item_px;
            pr.last = item_last;
          end
          pending_px.push_back(pr);
        end
      end
      if (out_tvalid && out_tready) begin
        act = 1;
        if (pending_px.size() == 0) begin
          report("unexpected result", out_tdata, 0);
        end else begin
          e = pending_px.pop_front();
          if (out_tdata[7:0] !== e.px[7:0]) report("red", out_tdata[7:0], e.px[7:0]);
          if (out_tdata[15:8] !== e.px[15:8]) report("green", out_tdata[15:8], e.px[15:8]);
          if (out_tdata[23:16] !== e.px[23:16]) report("blue", out_tdata[23:16], e.px[23:16]);
          if (out_tlast !== e.last) report("frame_last", out_tlast, e.last);
        end
      end
      idle_cycles <= act ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // receiver: random backpressure plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_tready <= 0;
    end else begin
      out_tready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  task automatic send(logic cmd, logic [23:0] px, bit typed, logic [23:0] wpx, bit wl);
    if ($urandom_range(99) < snd_idle) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= cmd;
    in_tdata <= px;
    item_typed <= typed;
    item_px <= wpx;
    item_last <= wl;
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  // drain all results, then let a trailing load settle
  task automatic wait_idle();
    in_tvalid <= 0;
    @(posedge clk);
    while (pending_px.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [7:0] val);
    wait_idle();
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
  endtask

  task automatic add(row_kind_t k, logic [2:0] i, logic [23:0] d, logic c,
                     bit t = 0, logic [23:0] wp = '0, bit wl = 0);
    row_t r;
    r.kind = k; r.idx = i; r.data = d; r.cmd = c;
    r.typed = t; r.want_px = wp; r.want_last = wl;
    rows.push_back(r);
  endtask

  // one random frame: configure, fill the whole source, then mostly emits
  task automatic random_frame(bit pressure);
    int unsigned w, h, n, sel;
    sel = $urandom_range(9);
    w = $urandom_range(1, 8);
    h = $urandom_range(1, 8);
    if (sel == 0) begin w = 128; h = 1; end
    if (sel == 1) begin w = 1; h = 128; end
    if (sel == 2) begin w = 128; h = 2; end
    write_reg(REG_SOURCE_WIDTH, 8'(w));
    write_reg(REG_SOURCE_HEIGHT, 8'(h));
    write_reg(REG_SCALE_NUM, 8'(sel == 2 ? 16 : $urandom_range(1, 16)));
    write_reg(REG_SCALE_DEN, 8'(sel == 2 ? 1 : $urandom_range(1, 16)));
    write_reg(REG_COLOR_MODE, 8'($urandom_range(1)));
    for (int i = 0; i < w * h; i++) send(CMD_LOAD, 24'($urandom), 0, '0, 0);
    if (pressure) hold_off = 600;
    n = pressure ? 30 : $urandom_range(10, 40);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 15) send(CMD_LOAD, 24'($urandom), 0, '0, 0);
      else send(CMD_EMIT, 24'($urandom), 0, '0, 0);
    end
  endtask

  initial begin
    row_t r;
    int target;
    rst_n = 0;
    cfg_valid = 0; cfg_index = '0; cfg_data = '0;
    in_tvalid = 0; in_tdata = '0; in_tuser = CMD_LOAD;
    item_typed = 0; item_px = '0; item_last = 0;
    errors = 0; idle_cycles = 0; hold_off = 0; sent = 0;
    snd_idle = 19; rcv_idle = 74;
    load_ptr = 0; col_cnt = 0; row_cnt = 0; src_x = 0; src_y = 0;
    reg_w = 128; reg_h = 128; reg_num = 1; reg_den = 1; reg_rgb = 0;
    foreach (pixel_store[i]) pixel_store[i] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // 2x2 gray at unity scale: outputs equal the loaded reds
    add(ROW_CFG, REG_SOURCE_WIDTH, 2, CMD_LOAD);
    add(ROW_CFG, REG_SOURCE_HEIGHT, 2, CMD_LOAD);
    add(ROW_PIX, 0, 24'hA5C300, CMD_LOAD);
    add(ROW_PIX, 0, 24'h0000FF, CMD_LOAD);
    add(ROW_PIX, 0, 24'hFFFF80, CMD_LOAD);
    add(ROW_PIX, 0, 24'h123401, CMD_LOAD);
    add(ROW_PIX, 0, 0, CMD_EMIT, 1, 24'h000000, 0);
    add(ROW_PIX, 0, 0, CMD_EMIT, 1, 24'h0000FF, 0);
    add(ROW_PIX, 0, 0, CMD_EMIT, 1, 24'h000080, 0);
    add(ROW_PIX, 0, 0, CMD_EMIT, 1, 24'h000001, 1);
    // rgb upscale 3/2, numerator masked to 5 bits, out-of-range index ignored
    add(ROW_CFG, REG_COLOR_MODE, 8'hFF, CMD_LOAD);
    add(ROW_CFG, REG_SCALE_NUM, 8'hE3, CMD_LOAD);
    add(ROW_CFG, REG_SCALE_DEN, 2, CMD_LOAD);
    add(ROW_CFG, 3'd7, 8'h55, CMD_LOAD);
    add(ROW_PIX, 0, 24'hFFFFFF, CMD_LOAD);
    add(ROW_PIX, 0, 24'h000000, CMD_LOAD);
    add(ROW_PIX, 0, 24'hFF00FF, CMD_LOAD);
    add(ROW_PIX, 0, 24'h00FF00, CMD_LOAD);
    for (int i = 0; i < 9; i++) add(ROW_PIX, 0, 24'($urandom), CMD_EMIT);
    // zero width, numerator and denominator collapse to one pixel
    add(ROW_CFG, REG_SOURCE_WIDTH, 0, CMD_LOAD);
    add(ROW_CFG, REG_SOURCE_HEIGHT, 1, CMD_LOAD);
    add(ROW_CFG, REG_SCALE_NUM, 0, CMD_LOAD);
    add(ROW_CFG, REG_SCALE_DEN, 0, CMD_LOAD);
    add(ROW_PIX, 0, 24'h7E81C3, CMD_LOAD);
    add(ROW_PIX, 0, 0, CMD_EMIT, 1, 24'h7E81C3, 1);

    foreach (rows[i]) begin
      r = rows[i];
      if (r.kind == ROW_CFG) write_reg(r.idx, r.data[7:0]);
      else send(r.cmd, r.data, r.typed, r.want_px, r.want_last);
    end

    // random frames in three flow modes
    for (int m = 0; m < 3; m++) begin
      if (m == 1) begin snd_idle = 74; rcv_idle = 19; end
      if (m == 2) begin snd_idle = 0; rcv_idle = 0; end
      target = sent + 250;
      if (m == 2) random_frame(1);
      while (sent < target) random_frame(0);
    end

    wait_idle();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/bis_pkg.sv
rtl/bilinear_image_scaler_unit.sv
dv/tb.sv
